[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold whenever the trigger is true
`define BSC_IMPLY(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("implication check failed");

// trigger must be followed by cond after a fixed number of cycles
`define BSC_DELAY(label, trig, dly, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cond)) \
    else $error("latency check failed");

`endif

[rtl/bsc_pkg.sv]
// package: constants and payload type of the box/sphere contact pipeline
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 17;
  localparam int LATENCY     = 6 + SQRT_STAGES + DIV_STAGES + 1;
  localparam logic [17:0] ONE_Q = 18'd65536;

  typedef struct packed {
    logic [2:0][31:0] point;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [30:0]      r;
    logic [30:0]      depth;
    logic             contact;
    logic             ozero;
    logic             origin;
  } payload_t;

endpackage

[rtl/bsc_sqrt.sv]
// pipelined integer square root, one result bit per stage, with a tag alongside
`timescale 1ns / 1ps
module bsc_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       in_s,
  input  bsc_pkg::payload_t in_tag,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output bsc_pkg::payload_t out_tag
);

  logic [63:0]       rem_q   [1:bsc_pkg::SQRT_STAGES];
  logic [31:0]       res_q   [1:bsc_pkg::SQRT_STAGES];
  logic              vld_q   [1:bsc_pkg::SQRT_STAGES];
  bsc_pkg::payload_t tag_q   [1:bsc_pkg::SQRT_STAGES];
  logic [63:0]       rem_c   [0:bsc_pkg::SQRT_STAGES-1];
  logic [31:0]       res_c   [0:bsc_pkg::SQRT_STAGES-1];
  logic [63:0]       rem_next[0:bsc_pkg::SQRT_STAGES-1];
  logic [31:0]       res_next[0:bsc_pkg::SQRT_STAGES-1];

  always_comb begin
    rem_c[0] = in_s;
    res_c[0] = '0;
    for (int k = 1; k < bsc_pkg::SQRT_STAGES; k++) begin
      rem_c[k] = rem_q[k];
      res_c[k] = res_q[k];
    end
    for (int k = 0; k < bsc_pkg::SQRT_STAGES; k++) begin
      // trial increment 2*res*2^b + 2^(2b) for bit b = 31 - k
      logic [63:0] trial;
      trial = (64'(res_c[k]) << (32 - k)) | (64'd1 << (62 - 2 * k));
      if (rem_c[k] >= trial) begin
        rem_next[k] = rem_c[k] - trial;
        res_next[k] = res_c[k] | (32'd1 << (31 - k));
      end else begin
        rem_next[k] = rem_c[k];
        res_next[k] = res_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < bsc_pkg::SQRT_STAGES; k++) begin
      rem_q[k+1] <= rem_next[k];
      res_q[k+1] <= res_next[k];
    end
    tag_q[1] <= in_tag;
    for (int k = 1; k < bsc_pkg::SQRT_STAGES; k++) begin
      tag_q[k+1] <= tag_q[k];
    end
    if (rst) begin
      for (int k = 1; k <= bsc_pkg::SQRT_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[1] <= in_valid;
      for (int k = 1; k < bsc_pkg::SQRT_STAGES; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign out_valid = vld_q[bsc_pkg::SQRT_STAGES];
  assign out_root  = res_q[bsc_pkg::SQRT_STAGES];
  assign out_tag   = tag_q[bsc_pkg::SQRT_STAGES];

endmodule

[rtl/bsc_norm_div.sv]
// pipelined restoring divide, three lanes of mag * 2^16 / len, one bit per stage
`timescale 1ns / 1ps
module bsc_norm_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       in_len,
  input  bsc_pkg::payload_t in_tag,
  output logic              out_valid,
  output logic [31:0]       out_len,
  output logic [2:0][16:0]  out_q,
  output logic [2:0][32:0]  out_rem,
  output bsc_pkg::payload_t out_tag
);

  localparam int N = bsc_pkg::DIV_STAGES;

  logic [2:0][32:0]  rem_q   [1:N];
  logic [2:0][16:0]  q_q     [1:N];
  logic [31:0]       len_q   [1:N];
  logic              vld_q   [1:N];
  bsc_pkg::payload_t tag_q   [1:N];
  logic [2:0][32:0]  rem_c   [0:N-1];
  logic [2:0][16:0]  q_c     [0:N-1];
  logic [31:0]       len_c   [0:N-1];
  logic [2:0][32:0]  rem_next[0:N-1];
  logic [2:0][16:0]  q_next  [0:N-1];

  always_comb begin
    len_c[0] = in_len;
    for (int l = 0; l < 3; l++) begin
      rem_c[0][l] = {1'b0, in_tag.mag[l]};
      q_c[0][l]   = '0;
    end
    for (int k = 1; k < N; k++) begin
      rem_c[k] = rem_q[k];
      q_c[k]   = q_q[k];
      len_c[k] = len_q[k];
    end
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 3; l++) begin
        logic [32:0] sh;
        logic        take;
        // first step compares the magnitude itself, later ones shift first
        sh   = (k == 0) ? rem_c[k][l] : {rem_c[k][l][31:0], 1'b0};
        take = sh >= {1'b0, len_c[k]};
        rem_next[k][l] = take ? (sh - {1'b0, len_c[k]}) : sh;
        q_next[k][l]   = {q_c[k][l][15:0], take};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      rem_q[k+1] <= rem_next[k];
      q_q[k+1]   <= q_next[k];
      len_q[k+1] <= len_c[k];
    end
    tag_q[1] <= in_tag;
    for (int k = 1; k < N; k++) begin
      tag_q[k+1] <= tag_q[k];
    end
    if (rst) begin
      for (int k = 1; k <= N; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[1] <= in_valid;
      for (int k = 1; k < N; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign out_valid = vld_q[N];
  assign out_len   = len_q[N];
  assign out_q     = q_q[N];
  assign out_rem   = rem_q[N];
  assign out_tag   = tag_q[N];

endmodule

[rtl/box_sphere_contact.sv]
// top level: streaming box/sphere contact test with closest point, normal and depth
// One box/sphere pair enters per clock whenever start is high; busy is tied low
// since the pipeline never stalls. Each item produces exactly one result, shown
// on the result ports for a single cycle with done high, after the item has
// passed 6 front stages (input, clamp, squares, two sums, contact decision), 32
// square-root stages, 17 divide stages and an output register. The receiver
// cannot hold results off, so the sink must take one result per cycle. When the
// sphere does not touch the box, contact_valid is low and point, normal and
// depth read zero. Values are signed or unsigned Q16.16; normals are signed Q2.16.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module box_sphere_contact (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [30:0]        half_extent_x,
  input  logic [30:0]        half_extent_y,
  input  logic [30:0]        half_extent_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        radius,
  output logic               done,
  output logic               contact_valid,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [30:0]        depth
);

  // stage 1: input register
  logic        v1;
  logic [2:0][30:0] ext1;
  logic [2:0][31:0] cen1;
  logic [30:0] r1;

  // stage 2: clamp, offset, vector choice
  logic              v2;
  bsc_pkg::payload_t t2;

  // stage 3: squares
  logic              v3;
  bsc_pkg::payload_t t3;
  logic [2:0][63:0]  sq3;
  logic [61:0]       rr3;

  // stage 4 and 5: sum of squares
  logic              v4, v5;
  bsc_pkg::payload_t t4, t5;
  logic [63:0]       s01_4, sq2_4, s5;
  logic [61:0]       rr4, rr5;

  // stage 6: contact decision
  logic              v6;
  bsc_pkg::payload_t t6, t6_next;
  logic [63:0]       s6;

  // square root and divide pipelines
  logic              sq_valid;
  logic [31:0]       sq_root;
  bsc_pkg::payload_t sq_tag, dv_in_tag;
  logic              dv_valid;
  logic [31:0]       dv_len;
  logic [2:0][16:0]  dv_q;
  logic [2:0][32:0]  dv_rem;
  bsc_pkg::payload_t dv_tag;

  bsc_pkg::payload_t t2_next;
  logic [2:0][17:0]  nrm_next;

  assign busy = 1'b0;

  // clamp the centre to the box per axis; pick offset, or centre when inside
  always_comb begin
    logic signed [32:0] c, e, p, o, v;
    logic [2:0] oz;
    t2_next = '0;
    for (int i = 0; i < 3; i++) begin
      c = {cen1[i][31], cen1[i]};
      e = {2'b00, ext1[i]};
      if (c < -e) begin
        p = -e;
      end else if (c > e) begin
        p = e;
      end else begin
        p = c;
      end
      o = c - p;
      oz[i] = (o == '0);
      t2_next.point[i] = p[31:0];
    end
    t2_next.ozero = &oz;
    for (int i = 0; i < 3; i++) begin
      c = {cen1[i][31], cen1[i]};
      e = {2'b00, ext1[i]};
      if (c < -e) begin
        p = -e;
      end else if (c > e) begin
        p = e;
      end else begin
        p = c;
      end
      o = c - p;
      v = t2_next.ozero ? c : o;
      t2_next.neg[i] = v[32];
      t2_next.mag[i] = v[32] ? 32'(-v) : v[31:0];
    end
    t2_next.origin = t2_next.ozero && (cen1[0] == '0) && (cen1[1] == '0) && (cen1[2] == '0);
    t2_next.r = r1;
  end

  always_comb begin
    t6_next         = t5;
    // inside the box always touches; else exact squared compare
    t6_next.contact = t5.ozero || (s5 <= 64'(rr5));
  end

  always_ff @(posedge clk) begin
    ext1  <= {half_extent_z, half_extent_y, half_extent_x};
    cen1  <= {center_z, center_y, center_x};
    r1    <= radius;
    t2    <= t2_next;
    t3    <= t2;
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= 64'(t2.mag[i]) * 64'(t2.mag[i]);
    end
    rr3   <= 62'(t2.r) * 62'(t2.r);
    t4    <= t3;
    s01_4 <= sq3[0] + sq3[1];
    sq2_4 <= sq3[2];
    rr4   <= rr3;
    t5    <= t4;
    s5    <= s01_4 + sq2_4;
    rr5   <= rr4;
    t6    <= t6_next;
    s6    <= s5;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  bsc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .in_s     (s6),
    .in_tag   (t6),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // depth uses the offset length, which is zero when the centre is inside
  always_comb begin
    dv_in_tag       = sq_tag;
    dv_in_tag.depth = sq_tag.ozero ? sq_tag.r : (sq_tag.r - sq_root[30:0]);
  end

  bsc_norm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_len   (sq_root),
    .in_tag   (dv_in_tag),
    .out_valid(dv_valid),
    .out_len  (dv_len),
    .out_q    (dv_q),
    .out_rem  (dv_rem),
    .out_tag  (dv_tag)
  );

  // round the magnitude half up, clamp to one, use +x at the origin, then apply the sign
  always_comb begin
    logic [17:0] qr;
    for (int i = 0; i < 3; i++) begin
      qr = {1'b0, dv_q[i]};
      if ({dv_rem[i], 1'b0} >= {2'b00, dv_len}) begin
        qr = qr + 18'd1;
      end
      if (qr > bsc_pkg::ONE_Q) begin
        qr = bsc_pkg::ONE_Q;
      end
      if (dv_tag.origin) begin
        qr = (i == 0) ? bsc_pkg::ONE_Q : 18'd0;
      end
      nrm_next[i] = (dv_tag.neg[i] && !dv_tag.origin) ? (18'd0 - qr) : qr;
    end
  end

  always_ff @(posedge clk) begin
    contact_valid <= dv_tag.contact;
    point_x  <= dv_tag.contact ? dv_tag.point[0] : '0;
    point_y  <= dv_tag.contact ? dv_tag.point[1] : '0;
    point_z  <= dv_tag.contact ? dv_tag.point[2] : '0;
    normal_x <= dv_tag.contact ? nrm_next[0] : '0;
    normal_y <= dv_tag.contact ? nrm_next[1] : '0;
    normal_z <= dv_tag.contact ? nrm_next[2] : '0;
    depth    <= dv_tag.contact ? dv_tag.depth : '0;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  `BSC_DELAY(a_latency, start && !busy, 56, done)
  `BSC_IMPLY(a_no_contact_zero, done && !contact_valid, depth == '0 && point_x == '0 && normal_x == '0)
  `BSC_IMPLY(a_normal_range, done && contact_valid, normal_x <= 18'sd65536 && normal_x >= -18'sd65536)
  `BSC_IMPLY(a_depth_bound, done && contact_valid, depth <= $past(dv_tag.r))

endmodule
